@@ rtl/core/hough_circle_event_accumulator_macros.svh @@
// Assertion macros for the Hough circle event accumulator.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef HOUGH_CIRCLE_EVENT_ACCUMULATOR_MACROS_SVH
`define HOUGH_CIRCLE_EVENT_ACCUMULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HCEA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcea check failed");
// next-cycle implication
`define HCEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcea check failed");
`else
`define HCEA_ASSERT_IMP(lbl, ante, cons)
`define HCEA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/hcea_pkg.sv @@
// Shared types and constants for the Hough circle event accumulator.
// No dependencies.
package hcea_pkg;

  localparam int SENSOR_WIDTH  = 346;
  localparam int SENSOR_HEIGHT = 260;
  localparam int VOTE_BITS     = 16;
  localparam int CELL_COUNT    = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int CELL_AW       = $clog2(CELL_COUNT);
  localparam logic [6:0] RADIUS_RESET = 7'd10;

  // tracer octant being walked
  typedef enum logic [2:0] {
    OCT_0, OCT_1, OCT_2, OCT_3, OCT_4, OCT_5, OCT_6, OCT_7
  } hcea_oct_e;

  typedef enum logic [2:0] {
    TRC_IDLE, TRC_SQ, TRC_INIT, TRC_RUN, TRC_SEC
  } hcea_trc_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_TRACE, ST_PT, ST_ADDR, ST_RMW, ST_DONE
  } hcea_state_e;

  // tracer status towards the voting controller
  typedef struct packed {
    logic              busy;
    logic              pt_valid;
    logic              done;
    logic signed [9:0] x;
    logic signed [9:0] y;
  } hcea_trc_t;

endpackage

@@ rtl/core/hcea_tracer.sv @@
// Midpoint circle stepper: walks eight octants and presents one offset pair per step.
// Depends on hcea_pkg.
module hcea_tracer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [6:0]         radius_i,
  input  logic               adv_i,
  output hcea_pkg::hcea_trc_t trc_o
);
  import hcea_pkg::*;

  typedef enum logic [1:0] {OP_XI, OP_XD, OP_YI, OP_YD} op_e;

  hcea_trc_e state_q, state_d;
  hcea_oct_e oct_q, oct_d;
  logic [6:0]         r_q;
  logic [13:0]        aa_q;
  logic signed [31:0] e_q, dx_q, dy_q, e_d, dx_d, dy_d;
  logic signed [9:0]  x_q, y_q, x_d, y_d;
  logic signed [31:0] a_s, k, e_new, test;
  logic               cond, sec_take, done;
  op_e                op;

  assign a_s = $signed(32'(aa_q));

  always_comb begin
    cond = 1'b0;
    op   = OP_XI;
    case (oct_q)
      OCT_0: cond = dy_q > dx_q;
      OCT_1: cond = dy_q > 0;
      OCT_2: cond = dy_q > -dx_q;
      OCT_3: cond = dx_q > 0;
      OCT_4: cond = (dy_q < dx_q) && (x_q > 0);
      OCT_5: cond = (dy_q < 0) && (x_q > 0);
      OCT_6: cond = (dy_q < -dx_q) && (x_q > 0);
      OCT_7: cond = (dy_q > 0) && (dx_q < 0) && (x_q > 0);
      default: cond = 1'b0;
    endcase
    if (state_q == TRC_SEC) begin
      case (oct_q)
        OCT_0, OCT_3: op = OP_XI;
        OCT_1, OCT_6: op = OP_YI;
        OCT_2, OCT_5: op = OP_YD;
        default:      op = OP_XD;
      endcase
    end else begin
      case (oct_q)
        OCT_0, OCT_7: op = OP_YI;
        OCT_1, OCT_2: op = OP_XI;
        OCT_3, OCT_4: op = OP_YD;
        default:      op = OP_XD;
      endcase
    end
  end

  always_comb begin
    case (op)
      OP_XI:   k = a_s - dy_q;
      OP_XD:   k = a_s + dy_q;
      OP_YI:   k = a_s + dx_q;
      default: k = a_s - dx_q;
    endcase
    e_new = e_q + k;
    test  = e_q + e_new;
    case (oct_q)
      OCT_0, OCT_2, OCT_4, OCT_6: sec_take = test > 0;
      default:                    sec_take = test < 0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    oct_d   = oct_q;
    e_d = e_q; dx_d = dx_q; dy_d = dy_q; x_d = x_q; y_d = y_q;
    done = 1'b0;
    case (state_q)
      TRC_IDLE: if (start_i) state_d = TRC_SQ;
      TRC_SQ:   state_d = TRC_INIT;
      TRC_INIT: begin
        x_d  = '0;
        y_d  = $signed({3'b000, r_q});
        e_d  = '0;
        dy_d = '0;
        dx_d = $signed(32'({aa_q, 1'b0}) * 32'(r_q));
        oct_d   = OCT_0;
        state_d = TRC_RUN;
      end
      TRC_RUN: begin
        if (!cond) begin
          if (oct_q == OCT_7) begin
            done    = 1'b1;
            state_d = TRC_IDLE;
          end else begin
            oct_d = hcea_oct_e'(oct_q + 3'd1);
          end
        end else if (adv_i) begin
          state_d = TRC_SEC;
        end
      end
      TRC_SEC:  state_d = TRC_RUN;
      default:  state_d = TRC_IDLE;
    endcase
    // primary step on advance, conditional step in TRC_SEC
    if ((state_q == TRC_RUN && cond && adv_i) || (state_q == TRC_SEC && sec_take)) begin
      e_d = e_new;
      case (op)
        OP_XI: begin dy_d = dy_q - 2 * a_s; x_d = x_q + 10'sd1; end
        OP_XD: begin dy_d = dy_q + 2 * a_s; x_d = x_q - 10'sd1; end
        OP_YI: begin dx_d = dx_q + 2 * a_s; y_d = y_q + 10'sd1; end
        default: begin dx_d = dx_q - 2 * a_s; y_d = y_q - 10'sd1; end
      endcase
    end
  end

  assign trc_o.done     = done;
  assign trc_o.busy     = state_q != TRC_IDLE;
  assign trc_o.pt_valid = (state_q == TRC_RUN) && cond;
  assign trc_o.x        = x_q;
  assign trc_o.y        = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TRC_IDLE;
      oct_q   <= OCT_0;
    end else begin
      state_q <= state_d;
      oct_q   <= oct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == TRC_IDLE) r_q <= radius_i;
    if (state_q == TRC_SQ) aa_q <= 14'(r_q) * 14'(r_q);
    e_q <= e_d; dx_q <= dx_d; dy_q <= dy_d; x_q <= x_d; y_q <= y_d;
  end

endmodule

@@ rtl/core/hough_circle_event_accumulator.sv @@
// Top level of the fixed-radius Hough circle voting block for event-camera events.
// Depends on hcea_pkg, hcea_tracer and hough_circle_event_accumulator_macros.svh.

// Each vote event traces a circle of the configured radius about (event_x, event_y) and,
// per traced step, increments the two mirrored cells (x+dx, y+dy) and (x-dx, y-dy) that
// fall on the sensor; every transfer in yields one transfer out carrying the running
// peak. Counts live in a single-port-write, registered-read memory of
// SENSOR_WIDTH*SENSOR_HEIGHT entries (89960 by default), updated by read-modify-write.
// A vote walks about 2.8*radius traced steps: per step the tracer presents the point
// and makes its conditional update, and each on-sensor cell passes through offset,
// read and write back, while an off-sensor cell skips the write back. Each octant
// change, setup and hand-off add to that; the memory read-modify-write sets the pace.
// No new transfer is taken until the result of the last one is loaded for output.
// A clear command (cmd 0) starts a clearing pass of one entry per cycle
// before the result and before the next input transfer; reset starts the same pass,
// which blocks the input but yields no result. Radius writes are taken at any time;
// a vote latches the radius when its transfer is accepted.
module hough_circle_event_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [9:0]  event_x_i,
  input  logic [9:0]  event_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  peak_x_o,
  output logic [9:0]  peak_y_o,
  output logic [15:0] peak_votes_o
);
  import hcea_pkg::*;
  `include "hough_circle_event_accumulator_macros.svh"

  localparam logic [VOTE_BITS-1:0] VOTE_MAX = '1;

  hcea_state_e state_q, state_d;
  hcea_trc_t   trc;

  logic [6:0]  radius_q;
  logic [9:0]  cx_q, cy_q;
  logic signed [9:0]  pt_x_q, pt_y_q;
  logic signed [11:0] px_q, py_q, px_d, py_d;
  logic        side_q;
  logic        boot_q;
  logic [CELL_AW-1:0] clr_q, addr_q, addr_calc;
  logic        in_acc, trc_start, trc_adv, rd_en, rmw_we, in_bounds;
  logic [VOTE_BITS-1:0] mem [CELL_COUNT];
  logic [VOTE_BITS-1:0] rdata_q, inc_val;
  logic [VOTE_BITS-1:0] best_votes_q;
  logic [9:0]  best_x_q, best_y_q;
  logic        out_valid_q, out_load;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == ST_IDLE;
  assign trc_start  = in_acc && cmd_i;

  hcea_tracer u_tracer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (trc_start),
    .radius_i (radius_q),
    .adv_i    (trc_adv),
    .trc_o    (trc)
  );

  // mirrored cell of the current step
  always_comb begin
    if (side_q) begin
      px_d = $signed({2'b00, cx_q}) - 12'(pt_x_q);
      py_d = $signed({2'b00, cy_q}) - 12'(pt_y_q);
    end else begin
      px_d = $signed({2'b00, cx_q}) + 12'(pt_x_q);
      py_d = $signed({2'b00, cy_q}) + 12'(pt_y_q);
    end
  end

  assign in_bounds = (px_q >= 0) && (px_q < $signed(12'(SENSOR_WIDTH))) &&
                     (py_q >= 0) && (py_q < $signed(12'(SENSOR_HEIGHT)));
  assign addr_calc = CELL_AW'(32'(px_q[9:0]) * SENSOR_HEIGHT + 32'(py_q[9:0]));
  assign inc_val   = (rdata_q == VOTE_MAX) ? rdata_q : rdata_q + 1'b1;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    trc_adv = 1'b0;
    rd_en   = 1'b0;
    rmw_we  = 1'b0;
    case (state_q)
      // the pass after reset answers no transfer
      ST_CLEAR: if (clr_q == CELL_AW'(CELL_COUNT - 1)) state_d = boot_q ? ST_IDLE : ST_DONE;
      ST_IDLE: begin
        if (in_acc) state_d = cmd_i ? ST_TRACE : ST_CLEAR;
      end
      ST_TRACE: begin
        if (trc.done) state_d = ST_DONE;
        else if (trc.pt_valid) state_d = ST_PT;
      end
      ST_PT: state_d = ST_ADDR;
      ST_ADDR: begin
        if (in_bounds) begin
          rd_en   = 1'b1;
          state_d = ST_RMW;
        end else if (side_q) begin
          trc_adv = 1'b1;
          state_d = ST_TRACE;
        end else begin
          state_d = ST_PT;
        end
      end
      ST_RMW: begin
        rmw_we = 1'b1;
        if (side_q) begin
          trc_adv = 1'b1;
          state_d = ST_TRACE;
        end else begin
          state_d = ST_PT;
        end
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      radius_q     <= RADIUS_RESET;
      clr_q        <= '0;
      side_q       <= 1'b0;
      boot_q       <= 1'b1;
      best_votes_q <= '0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      else clr_q <= '0;
      if (state_q == ST_CLEAR && clr_q == CELL_AW'(CELL_COUNT - 1)) boot_q <= 1'b0;
      if (state_q == ST_TRACE) side_q <= 1'b0;
      else if ((state_q == ST_ADDR && !in_bounds) || state_q == ST_RMW) side_q <= 1'b1;
      if (in_acc && !cmd_i) begin
        best_votes_q <= '0;
        best_x_q     <= '0;
        best_y_q     <= '0;
      end else if (rmw_we && inc_val >= best_votes_q) begin
        best_votes_q <= inc_val;
        best_x_q     <= px_q[9:0];
        best_y_q     <= py_q[9:0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q <= event_x_i;
      cy_q <= event_y_i;
    end
    if (state_q == ST_TRACE && trc.pt_valid) begin
      pt_x_q <= trc.x;
      pt_y_q <= trc.y;
    end
    if (state_q == ST_PT) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (rd_en) addr_q <= addr_calc;
    if (out_load) begin
      peak_x_o     <= best_x_q;
      peak_y_o     <= best_y_q;
      peak_votes_o <= 16'(best_votes_q);
    end
  end

  // vote memory: registered read, one write port shared by clearing and voting
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[addr_calc];
    if (state_q == ST_CLEAR) mem[clr_q] <= '0;
    else if (rmw_we) mem[addr_q] <= inc_val;
  end

  assign out_valid_o = out_valid_q;

  `HCEA_ASSERT_IMP(a_idle_trc_quiet, in_ready_o, !trc.busy)
  `HCEA_ASSERT_IMP(a_adv_on_point, trc_adv, trc.pt_valid)
  `HCEA_ASSERT_NEXT(a_peak_monotone, state_q != ST_CLEAR && !(in_acc && !cmd_i),
                    best_votes_q >= $past(best_votes_q))

endmodule

@@ tb/tb_hough_circle_event_accumulator.sv @@
// Testbench for hough_circle_event_accumulator: a queue-fed driver and a monitor,
// checked against an in-bench circle voting predictor. Depends on hcea_pkg and the RTL.
module tb_hough_circle_event_accumulator;
  import hcea_pkg::*;

  typedef struct {
    logic       cmd;
    logic [9:0] ex;
    logic [9:0] ey;
  } event_t;

  typedef struct {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [15:0] votes;
  } peak_t;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_VOTE  = 1'b1;
  localparam int unsigned COUNT_MAX = (1 << VOTE_BITS) - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [9:0]  event_x_i = '0;
  logic [9:0]  event_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  peak_x_o;
  logic [9:0]  peak_y_o;
  logic [15:0] peak_votes_o;

  hough_circle_event_accumulator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .event_x_i, .event_y_i,
    .out_valid_o, .out_ready_i, .peak_x_o, .peak_y_o, .peak_votes_o
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  int unsigned vote_count [CELL_COUNT];
  int unsigned top_votes, top_x, top_y;
  int unsigned radius_now = RADIUS_RESET;

  event_t pending_events [$];
  peak_t  peak_queue [$];
  int     mismatches = 0;
  int     n_accepted = 0;
  bit     calm = 1'b0;   // no idling while set

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  function automatic void wipe_votes();
    foreach (vote_count[i]) vote_count[i] = 0;
    top_votes = 0; top_x = 0; top_y = 0;
  endfunction

  function automatic void add_vote(longint px, longint py);
    int unsigned c;
    if (px < 0 || px >= SENSOR_WIDTH || py < 0 || py >= SENSOR_HEIGHT) return;
    c = int'(px) * SENSOR_HEIGHT + int'(py);
    if (vote_count[c] < COUNT_MAX) vote_count[c]++;
    if (vote_count[c] >= top_votes) begin
      top_votes = vote_count[c]; top_x = 32'(px); top_y = 32'(py);
    end
  endfunction

  // eight-sector midpoint stepping, a = b = r
  function automatic void trace_votes(longint cx, longint cy, longint r);
    longint aa, bb, x, y, dx, dy, e;
    aa = r * r; bb = aa; x = 0; y = r; dx = 2 * aa * y; dy = 0; e = aa * (y * y - bb);
    while (dy > dx) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e += dx + aa; dx += 2 * aa; y++;
      if (2 * e - dy + bb > 0) begin e = e - dy + bb; dy -= 2 * bb; x++; end
    end
    while (dy > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e = e - dy + bb; dy -= 2 * bb; x++;
      if (2 * e + dx + aa < 0) begin e += dx + aa; dx += 2 * aa; y++; end
    end
    while (dy > -dx) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e = e - dy + bb; dy -= 2 * bb; x++;
      if (2 * e - dx + aa > 0) begin e = e - dx + aa; dx -= 2 * aa; y--; end
    end
    while (dx > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e = e - dx + aa; dx -= 2 * aa; y--;
      if (2 * e - dy + bb < 0) begin e = e - dy + bb; dy -= 2 * bb; x++; end
    end
    while (dy < dx && x > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e = e - dx + aa; dx -= 2 * aa; y--;
      if (2 * e + dy + bb > 0) begin e += dy + bb; dy += 2 * bb; x--; end
    end
    while (dy < 0 && x > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e += dy + bb; dy += 2 * bb; x--;
      if (2 * e - dx + aa < 0) begin e = e - dx + aa; dx -= 2 * aa; y--; end
    end
    while (dy < -dx && x > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e += dy + bb; dy += 2 * bb; x--;
      if (2 * e + dx + aa > 0) begin e += dx + aa; dx += 2 * aa; y++; end
    end
    while (dy > 0 && dx < 0 && x > 0) begin
      add_vote(cx + x, cy + y); add_vote(cx - x, cy - y);
      e += dx + aa; dx += 2 * aa; y++;
      if (2 * e + dy + bb < 0) begin e += dy + bb; dy += 2 * bb; x--; end
    end
  endfunction

  function automatic void predict_peak(event_t ev);
    peak_t p;
    if (ev.cmd == CMD_CLEAR) wipe_votes();
    else trace_votes(ev.ex, ev.ey, radius_now);
    p.px = top_x[9:0]; p.py = top_y[9:0]; p.votes = top_votes[15:0];
    peak_queue = {peak_queue, p};
  endfunction

  // driver: predicts each transfer as it is taken, then offers the next item
  always @(posedge clk_i) begin
    event_t ev;
    if (in_valid_i && in_ready_o) begin
      predict_peak('{cmd_i, event_x_i, event_y_i});
      n_accepted++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (pending_events.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
        ev = pending_events.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= ev.cmd; event_x_i <= ev.ex; event_y_i <= ev.ey;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off once, so the block backs up onto its input
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (!hold_done && n_accepted >= 300) begin
      hold_left <= 3000; hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    peak_t p;
    if (out_valid_o && out_ready_i) begin
      if (peak_queue.size() == 0) report("unexpected transfer", 1, 0);
      else begin
        p = peak_queue.pop_front();
        if (peak_x_o !== p.px) report("peak_x", peak_x_o, p.px);
        if (peak_y_o !== p.py) report("peak_y", peak_y_o, p.py);
        if (peak_votes_o !== p.votes) report("peak_votes", peak_votes_o, p.votes);
      end
    end
    out_ready_i <= (hold_left == 0) && (calm || $urandom_range(99) >= 11);
  end

  task automatic queue_event(logic cmd, int x, int y);
    event_t ev;
    ev.cmd = cmd; ev.ex = x[9:0]; ev.ey = y[9:0];
    pending_events = {pending_events, ev};
  endtask

  task automatic drain();
    wait (pending_events.size() == 0 && !in_valid_i && peak_queue.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_radius(int r);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= r[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_now = r & 7'h7f;
  endtask

  // random phase: events clustered around a point on the sensor plus stray ones anywhere
  task automatic random_phase(int n, int r);
    int cx, cy;
    set_radius(r);
    cx = $urandom_range(SENSOR_WIDTH - 1); cy = $urandom_range(SENSOR_HEIGHT - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75)
        queue_event(CMD_VOTE, cx + $urandom_range(2 * r + 4) - r - 2,
                    cy + $urandom_range(2 * r + 4) - r - 2);
      else if ($urandom_range(99) < 60)
        queue_event(CMD_VOTE, $urandom_range(SENSOR_WIDTH - 1),
                    $urandom_range(SENSOR_HEIGHT - 1));
      else
        queue_event(CMD_VOTE, $urandom_range(1023), $urandom_range(1023));
    end
  endtask

  initial begin
    wipe_votes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, off-sensor events, ties on one spot, radius extremes, clear
    queue_event(CMD_VOTE, 0, 0);
    queue_event(CMD_VOTE, SENSOR_WIDTH - 1, SENSOR_HEIGHT - 1);
    queue_event(CMD_VOTE, 1023, 1023);
    queue_event(CMD_VOTE, 1023, 0);
    queue_event(CMD_VOTE, SENSOR_WIDTH + 5, 100);
    queue_event(CMD_VOTE, 100, 100);
    queue_event(CMD_VOTE, 100, 100);
    queue_event(CMD_VOTE, 102, 99);
    queue_event(CMD_CLEAR, 1023, 1023);
    queue_event(CMD_VOTE, 50, 50);
    set_radius(1);
    queue_event(CMD_VOTE, 0, 0);
    queue_event(CMD_VOTE, 1, 1);
    queue_event(CMD_VOTE, 200, 130);
    queue_event(CMD_VOTE, 200, 130);
    set_radius(0);
    queue_event(CMD_VOTE, 10, 10);
    queue_event(CMD_VOTE, 1023, 0);
    set_radius(127);
    queue_event(CMD_VOTE, 173, 130);
    queue_event(CMD_VOTE, 0, 1023);
    queue_event(CMD_VOTE, 1023, 511);

    // random: mostly small radii, a calm stretch, one more clear
    random_phase(500, 3);
    calm = 1'b1;
    random_phase(300, 2);
    calm = 1'b0;
    random_phase(300, 5);
    queue_event(CMD_CLEAR, $urandom_range(1023), $urandom_range(1023));
    random_phase(400, 1);
    random_phase(300, $urandom_range(4, 9));
    random_phase(6, 127);
    random_phase(80, 12);
    set_radius(RADIUS_RESET);
    queue_event(CMD_VOTE, 170, 120);

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
